/* design/fpc_pkg.sv */
// ----------------------------------------------------------------------------
// fpc_pkg: shared types and constants of the frustum plane cull unit
// Action and visibility codes, queue depths and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT  = 16;
  localparam int unsigned WORD_WIDTH_DEFAULT = 32;

  localparam int unsigned PLANE_COUNT   = 6;
  localparam int unsigned COEFF_COUNT   = 4;
  localparam int unsigned MATRIX_DEPTH  = 16;
  localparam int unsigned INDEX_W       = 4;
  localparam int unsigned PLANE_IDX_W   = 3;
  localparam int unsigned CMD_Q_DEPTH   = 4;
  localparam int unsigned RES_Q_DEPTH   = 2;

  localparam logic [PLANE_IDX_W-1:0] NO_PLANE   = PLANE_IDX_W'(PLANE_COUNT);
  localparam logic [PLANE_IDX_W-1:0] LAST_PLANE = PLANE_IDX_W'(PLANE_COUNT - 1);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DERIVE = 2'd1,
    ACT_POINT  = 2'd2,
    ACT_SPHERE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    VIS_OUTSIDE   = 2'd0,
    VIS_INTERSECT = 2'd1,
    VIS_INSIDE    = 2'd2
  } vis_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_TEST = 1'b1
  } back_state_e;

  typedef struct packed {
    action_e              action;
    logic [INDEX_W-1:0]   index;
  } cmd_ctrl_t;

  typedef struct packed {
    vis_e                   visibility;
    logic [PLANE_IDX_W-1:0] plane;
  } result_t;

endpackage

`default_nettype wire

/* design/frustum_plane_cull_unit.sv */
// ----------------------------------------------------------------------------
// frustum_plane_cull_unit: view frustum culling of points and spheres
// Loads a view-projection matrix, derives six clip planes and classifies
// points and spheres against them in Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------
//   input     push / full        action, element index/value, point, radius
//   result    pop  / empty       visibility, deciding plane
//
// - an input register takes one item a cycle until the command queue fills
// - loads and derives give no result
// - a test captures its operands, then issues one plane per cycle into a
//   three-stage multiply/add pipeline and is decided on the first deciding
//   plane or after the last one
// - reset clears all control state; matrix and plane stores are not reset
// - a stalled result side holds tests in the command queue; loads and derives
//   queued ahead of them still drain
`default_nettype none

module frustum_plane_cull_unit
  import fpc_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input queue side
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            action_i,
  input  wire logic [INDEX_W-1:0]    element_index_i,
  input  wire logic [WORD_WIDTH-1:0] element_value_i,
  input  wire logic [WORD_WIDTH-1:0] point_x_i,
  input  wire logic [WORD_WIDTH-1:0] point_y_i,
  input  wire logic [WORD_WIDTH-1:0] point_z_i,
  input  wire logic [WORD_WIDTH-2:0] sphere_radius_i,
  // result queue side
  output logic                       empty,
  input  wire logic                  pop,
  output logic [1:0]                 visibility_o,
  output logic [PLANE_IDX_W-1:0]     deciding_plane_o
);

  // command word: control, three operand words, radius
  localparam int unsigned CMD_W = $bits(cmd_ctrl_t) + 4 * WORD_WIDTH - 1;

  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_in, cmd_out;

  logic             res_push, res_full;
  result_t          res_in, res_out;

  // front: input register and classification
  fpc_front #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .action_i        (action_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .sphere_radius_i (sphere_radius_i),
    .cmd_push_o      (cmd_push),
    .cmd_full_i      (cmd_full),
    .cmd_data_o      (cmd_in)
  );

  // command queue decouples front from back
  fpc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: stores, plane derivation and plane test pipeline
  fpc_back #(
    .FRAC_BITS  (FRAC_BITS),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_data_i  (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue is the output register
  fpc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign visibility_o     = res_out.visibility;
  assign deciding_plane_o = res_out.plane;

endmodule

`default_nettype wire

/* design/fpc_fifo.sv */
// ----------------------------------------------------------------------------
// fpc_fifo: small register queue
// Flop-based fifo with a combinational head read, used for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* design/fpc_front.sv */
// ----------------------------------------------------------------------------
// fpc_front: input stage
// Registers one item, classifies it and packs it into a command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_front
  import fpc_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  output logic                         full_o,
  input  wire logic [1:0]              action_i,
  input  wire logic [INDEX_W-1:0]      element_index_i,
  input  wire logic [WORD_WIDTH-1:0]   element_value_i,
  input  wire logic [WORD_WIDTH-1:0]   point_x_i,
  input  wire logic [WORD_WIDTH-1:0]   point_y_i,
  input  wire logic [WORD_WIDTH-1:0]   point_z_i,
  input  wire logic [WORD_WIDTH-2:0]   sphere_radius_i,
  output logic                         cmd_push_o,
  input  wire logic                    cmd_full_i,
  output logic [$bits(cmd_ctrl_t)+4*WORD_WIDTH-2:0] cmd_data_o
);

  logic                  valid_q, valid_d;
  logic                  accept, forward;
  cmd_ctrl_t             ctrl_q, ctrl_d;
  logic [WORD_WIDTH-1:0] a_q, b_q, c_q;
  logic [WORD_WIDTH-2:0] r_q;

  assign forward = valid_q && !cmd_full_i;
  assign full_o  = valid_q && cmd_full_i;
  assign accept  = push_i && !full_o;

  // loads carry their element in the first operand slot
  always_comb begin
    ctrl_d.action = action_e'(action_i);
    ctrl_d.index  = element_index_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (forward) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_d;
      a_q    <= (ctrl_d.action == ACT_LOAD) ? element_value_i : point_x_i;
      b_q    <= point_y_i;
      c_q    <= point_z_i;
      r_q    <= sphere_radius_i;
    end
  end

  assign cmd_push_o = valid_q;
  assign cmd_data_o = {ctrl_q, a_q, b_q, c_q, r_q};

endmodule

`default_nettype wire

/* design/fpc_back.sv */
// ----------------------------------------------------------------------------
// fpc_back: execution stage
// Holds matrix and planes, derives planes and runs plane tests in a pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_back
  import fpc_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  input  wire logic [$bits(cmd_ctrl_t)+4*WORD_WIDTH-2:0] cmd_data_i,
  output logic       cmd_pop_o,
  input  wire logic  res_full_i,
  output logic       res_push_o,
  output result_t    res_o
);

  localparam int unsigned W  = WORD_WIDTH;
  localparam int unsigned CW = W + 1;
  localparam int unsigned PW = CW + W;
  localparam int unsigned DW = 2 * W + 3;

  cmd_ctrl_t      cmd_ctrl;
  logic [W-1:0]   cmd_a, cmd_b, cmd_c;
  logic [W-2:0]   cmd_r;

  assign {cmd_ctrl, cmd_a, cmd_b, cmd_c, cmd_r} = cmd_data_i;

  back_state_e state_q, state_d;
  logic load_en, derive_en, capture_en;

  logic [W-1:0]  matrix_q [MATRIX_DEPTH];
  logic [CW-1:0] plane_q  [PLANE_COUNT][COEFF_COUNT];
  logic [CW-1:0] plane_d  [PLANE_COUNT][COEFF_COUNT];

  logic [W-1:0]         px_q, py_q, pz_q;
  logic signed [DW-1:0] rq_q, nr_q, rq_d;
  logic                 sphere_q;

  logic [PLANE_IDX_W-1:0] issue_q, issue_d;
  logic                   issue_go;

  logic                   s1_valid_q, s2_valid_q, s3_valid_q;
  logic [PLANE_IDX_W-1:0] s1_plane_q, s2_plane_q, s3_plane_q;
  logic signed [DW-1:0]   prod_q [COEFF_COUNT];
  logic signed [DW-1:0]   part_q [2];
  logic signed [DW-1:0]   dist_q;
  logic signed [PW-1:0]   mul_x, mul_y, mul_z;

  logic    hit, finish;
  vis_e    hit_vis;

  // ---- control ----
  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    load_en    = 1'b0;
    derive_en  = 1'b0;
    capture_en = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_ctrl.action)
            ACT_LOAD: begin
              load_en   = 1'b1;
              cmd_pop_o = 1'b1;
            end
            ACT_DERIVE: begin
              derive_en = 1'b1;
              cmd_pop_o = 1'b1;
            end
            default: begin
              // a test starts only with room for its result
              if (!res_full_i) begin
                capture_en = 1'b1;
                cmd_pop_o  = 1'b1;
                state_d    = BK_TEST;
              end
            end
          endcase
        end
      end
      BK_TEST: begin
        if (finish) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---- matrix and plane stores ----
  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int k = 0; k < COEFF_COUNT; k++) begin
        if ((p & 1) != 0) begin
          plane_d[p][k] = CW'($signed(matrix_q[3 + 4 * k]))
                        - CW'($signed(matrix_q[(p >> 1) + 4 * k]));
        end else begin
          plane_d[p][k] = CW'($signed(matrix_q[3 + 4 * k]))
                        + CW'($signed(matrix_q[(p >> 1) + 4 * k]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      matrix_q[cmd_ctrl.index] <= cmd_a;
    end
    if (derive_en) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int k = 0; k < COEFF_COUNT; k++) begin
          plane_q[p][k] <= plane_d[p][k];
        end
      end
    end
  end

  // ---- test operands ----
  assign rq_d = $signed(DW'(cmd_r) << FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (capture_en) begin
      px_q     <= cmd_a;
      py_q     <= cmd_b;
      pz_q     <= cmd_c;
      rq_q     <= rq_d;
      nr_q     <= -rq_d;
      sphere_q <= (cmd_ctrl.action == ACT_SPHERE);
    end
  end

  // ---- plane pipeline: products, partial sums, distance ----
  assign issue_go = (state_q == BK_TEST) && (issue_q < NO_PLANE) && !finish;

  always_comb begin
    issue_d = issue_q;
    if (capture_en) begin
      issue_d = '0;
    end else if (issue_go) begin
      issue_d = issue_q + PLANE_IDX_W'(1);
    end
  end

  assign mul_x = $signed(plane_q[issue_q][0]) * $signed(px_q);
  assign mul_y = $signed(plane_q[issue_q][1]) * $signed(py_q);
  assign mul_z = $signed(plane_q[issue_q][2]) * $signed(pz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      issue_q    <= issue_d;
      s1_valid_q <= issue_go;
      s2_valid_q <= s1_valid_q && !finish;
      s3_valid_q <= s2_valid_q && !finish;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_plane_q <= issue_q;
    prod_q[0]  <= DW'(mul_x);
    prod_q[1]  <= DW'(mul_y);
    prod_q[2]  <= DW'(mul_z);
    prod_q[3]  <= DW'($signed(plane_q[issue_q][3])) <<< FRAC_BITS;
    s2_plane_q <= s1_plane_q;
    part_q[0]  <= prod_q[0] + prod_q[1];
    part_q[1]  <= prod_q[2] + prod_q[3];
    s3_plane_q <= s2_plane_q;
    dist_q     <= part_q[0] + part_q[1];
  end

  // ---- decision, first deciding plane wins ----
  always_comb begin
    hit     = 1'b0;
    hit_vis = VIS_INSIDE;
    if (sphere_q) begin
      if (dist_q < nr_q) begin
        hit     = 1'b1;
        hit_vis = VIS_OUTSIDE;
      end else if ((dist_q < rq_q) && (nr_q < dist_q)) begin
        hit     = 1'b1;
        hit_vis = VIS_INTERSECT;
      end
    end else if (dist_q < 0) begin
      hit     = 1'b1;
      hit_vis = VIS_OUTSIDE;
    end
  end

  assign finish     = s3_valid_q && (hit || (s3_plane_q == LAST_PLANE));
  assign res_push_o = finish;

  always_comb begin
    res_o.visibility = hit ? hit_vis : VIS_INSIDE;
    res_o.plane      = hit ? s3_plane_q : NO_PLANE;
  end

  // ---- checks ----
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full result queue");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) |-> (!s1_valid_q && !s2_valid_q && !s3_valid_q))
    else $error("plane pipeline busy while idle");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q <= NO_PLANE)
    else $error("plane issue counter out of range");

  a_push_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (state_q == BK_IDLE))
    else $error("test did not end after its result");

endmodule

`default_nettype wire

/* sim/frustum_plane_cull_unit_tb.sv */
// ----------------------------------------------------------------------------
// frustum_plane_cull_unit_tb: self-checking bench of the frustum plane cull unit
// Loads view-projection matrices, derives planes and fires point and sphere
// tests through the push/full side while the pop/empty side drains results.
// A scoreboard class predicts each visibility and deciding plane exactly and
// compares them in order against what the unit returns.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_plane_cull_unit_tb;
  import fpc_pkg::*;

  localparam int unsigned W = WORD_WIDTH_DEFAULT;
  localparam int unsigned F = FRAC_BITS_DEFAULT;

  // 1.0 in the matrix and coordinate format
  localparam logic [W-1:0] ONE = W'(1) << F;

  // worst case is far below this: ~480 items, plus idling gaps, stalls and the
  // long receiver hold
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_GOAL   = 450;
  localparam int unsigned HOLD_LEN    = 150;
  localparam int unsigned TAIL_CYCLES = 30;

  // one input item as offered on the push side
  typedef struct {
    action_e        act;
    logic [3:0]     index;
    logic [W-1:0]   value;
    logic [W-1:0]   px;
    logic [W-1:0]   py;
    logic [W-1:0]   pz;
    logic [W-2:0]   radius;
  } cull_item_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of matrix and planes, queue of pending verdicts
  // --------------------------------------------------------------------------
  class cull_scoreboard;
    logic signed [W-1:0] matrix [16];
    logic signed [W:0]   planes [24];
    result_t             verdict_q [$];
    int unsigned         n_errors;

    function new();
      n_errors = 0;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // exact signed distance with 2*F fraction bits
    function logic signed [127:0] dist_to_plane(int p, logic signed [W-1:0] x,
                                                logic signed [W-1:0] y,
                                                logic signed [W-1:0] z);
      logic signed [127:0] acc, c, v;
      c = planes[4*p+3];
      acc = c <<< F;
      c = planes[4*p];
      v = x;
      acc = acc + c * v;
      c = planes[4*p+1];
      v = y;
      acc = acc + c * v;
      c = planes[4*p+2];
      v = z;
      acc = acc + c * v;
      return acc;
    endfunction

    function void note_item(cull_item_t it);
      logic signed [W:0]   base, other;
      logic signed [127:0] d, rq, nr;
      result_t             res;
      bit                  decided;
      case (it.act)
        ACT_LOAD: begin
          matrix[it.index] = it.value;
        end
        ACT_DERIVE: begin
          // plane p: column 3 plus (even p) or minus (odd p) column p/2
          for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int k = 0; k < COEFF_COUNT; k++) begin
              base  = matrix[3 + 4*k];
              other = matrix[p/2 + 4*k];
              planes[4*p + k] = (p % 2) ? base - other : base + other;
            end
          end
        end
        default: begin
          res.visibility = VIS_INSIDE;
          res.plane = NO_PLANE;
          decided = 1'b0;
          rq = {{(129-W){1'b0}}, it.radius};
          rq = rq <<< F;
          nr = -rq;
          for (int p = 0; p < PLANE_COUNT && !decided; p++) begin
            d = dist_to_plane(p, it.px, it.py, it.pz);
            if (it.act == ACT_POINT) begin
              if (d < 0) begin
                res.visibility = VIS_OUTSIDE;
                res.plane = PLANE_IDX_W'(p);
                decided = 1'b1;
              end
            end else if (d < nr) begin
              res.visibility = VIS_OUTSIDE;
              res.plane = PLANE_IDX_W'(p);
              decided = 1'b1;
            end else if (d < rq && d > nr) begin
              res.visibility = VIS_INTERSECT;
              res.plane = PLANE_IDX_W'(p);
              decided = 1'b1;
            end
          end
          verdict_q = {verdict_q, res};
        end
      endcase
    endfunction

    function void check_result(logic [1:0] vis, logic [PLANE_IDX_W-1:0] plane);
      result_t want;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: visibility %0d deciding_plane %0d", vis, plane);
        n_errors++;
      end else begin
        want = verdict_q.pop_front();
        if (vis !== want.visibility) begin
          $error("visibility: expected %0d, actual %0d", want.visibility, vis);
          n_errors++;
        end
        if (plane !== want.plane) begin
          $error("deciding_plane: expected %0d, actual %0d", want.plane, plane);
          n_errors++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   push = 1'b0;
  logic                   full;
  logic [1:0]             action = ACT_LOAD;
  logic [3:0]             element_index = '0;
  logic [W-1:0]           element_value = '0;
  logic [W-1:0]           point_x = '0;
  logic [W-1:0]           point_y = '0;
  logic [W-1:0]           point_z = '0;
  logic [W-2:0]           sphere_radius = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [1:0]             visibility;
  logic [PLANE_IDX_W-1:0] deciding_plane;

  cull_scoreboard sb;
  cull_item_t     cur_item;      // item currently on the push side
  int unsigned    idle_pct = 0;  // sender idle chance per cycle
  int unsigned    stall_pct = 0; // receiver stall chance per cycle
  int unsigned    hold_left = 0; // long receiver hold, counted down below
  int unsigned    n_sent = 0;
  int unsigned    cycle_count = 0;

  frustum_plane_cull_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .action_i         (action),
    .element_index_i  (element_index),
    .element_value_i  (element_value),
    .point_x_i        (point_x),
    .point_y_i        (point_y),
    .point_z_i        (point_z),
    .sphere_radius_i  (sphere_radius),
    .empty            (empty),
    .pop              (pop),
    .visibility_o     (visibility),
    .deciding_plane_o (deciding_plane)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // monitor: sample both handshakes with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_item(cur_item);
      end
      if (pop && !empty) begin
        sb.check_result(visibility, deciding_plane);
      end
    end
  end

  // receiver: random stalls, plus one long hold counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // item builders
  // --------------------------------------------------------------------------
  function automatic cull_item_t mk_item(action_e act, logic [3:0] idx,
                                         logic [W-1:0] val, logic [W-1:0] x,
                                         logic [W-1:0] y, logic [W-1:0] z,
                                         logic [W-2:0] rad);
    cull_item_t it;
    it.act = act;
    it.index = idx;
    it.value = val;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.radius = rad;
    return it;
  endfunction

  // random value in [-span, span], Q16.16
  function automatic logic [W-1:0] near_unit(int unsigned span);
    return W'($urandom_range(2 * span)) - W'(span);
  endfunction

  // test coordinate: mostly near the unit cube, some on integer boundaries,
  // some across the whole word
  function automatic logic [W-1:0] coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return near_unit(2 * ONE);
    if (sel < 80) return W'($urandom_range(4)) * ONE - 2 * ONE;
    return W'($urandom);
  endfunction

  // unused fields carry noise; the block must ignore them
  function automatic cull_item_t noise_item(action_e act);
    return mk_item(act, 4'($urandom), W'($urandom), W'($urandom), W'($urandom),
                   W'($urandom), (W-1)'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // sender: offer one item and hold it until accepted
  // --------------------------------------------------------------------------
  task automatic send_item(input cull_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    cur_item <= it;
    push <= 1'b1;
    action <= it.act;
    element_index <= it.index;
    element_value <= it.value;
    point_x <= it.px;
    point_y <= it.py;
    point_z <= it.pz;
    sphere_radius <= it.radius;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_sent++;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    cull_item_t  it;
    int unsigned sel, style, base_count;
    logic [W-1:0] diag;

    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: element extremes first, overwritten by the identity below
    send_item(mk_item(ACT_LOAD, 4'd1, {1'b1, {(W-1){1'b0}}}, '0, '0, '0, '0));
    send_item(mk_item(ACT_LOAD, 4'd2, {1'b0, {(W-1){1'b1}}}, '1, '1, '1, '1));
    // identity matrix: planes become x+1, -x+1, y+1, -y+1, z+1, -z+1
    for (int e = 0; e < 16; e++) begin
      send_item(mk_item(ACT_LOAD, 4'(e), (e % 5 == 0) ? ONE : '0,
                        {1'b1, {(W-1){1'b0}}}, '1, '0, '1));
    end
    send_item(mk_item(ACT_DERIVE, 4'hf, '1, '1, '1, '1, '1));
    // point at the origin is inside
    send_item(mk_item(ACT_POINT, '1, '1, '0, '0, '0, '1));
    // point exactly on the left plane counts as inside
    send_item(mk_item(ACT_POINT, '0, '0, -ONE, '0, '0, '0));
    // one lsb past the left plane
    send_item(mk_item(ACT_POINT, '0, '0, -ONE - 1, '0, '0, '0));
    // most positive z, outside the far plane
    send_item(mk_item(ACT_POINT, '0, '0, '0, '0, {1'b0, {(W-1){1'b1}}}, '0));
    // zero radius: inside at the origin, outside beyond the left plane
    send_item(mk_item(ACT_SPHERE, '0, '0, '0, '0, '0, '0));
    send_item(mk_item(ACT_SPHERE, '0, '0, -2 * ONE, '0, '0, '0));
    // sphere touching the left plane from outside at exactly minus radius
    send_item(mk_item(ACT_SPHERE, '0, '0, -ONE - ONE / 2, '0, '0,
                      (W-1)'(ONE / 2)));
    // huge radius intersects the very first plane
    send_item(mk_item(ACT_SPHERE, '0, '0, '0, '0, '0, '1));
    // centered on the top plane, decided there
    send_item(mk_item(ACT_SPHERE, '0, '0, '0, ONE, '0, (W-1)'(ONE / 4)));
    base_count = n_sent;

    // random phases: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          // block fills up while the sender keeps offering
          hold_left = HOLD_LEN;
        end
        1: begin
          idle_pct = 67;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 67;
        end
        default: begin
          idle_pct = 14;
          stall_pct = 14;
        end
      endcase
      while (n_sent < base_count + ITEM_GOAL * (ph + 1) / 4) begin
        sel = $urandom_range(99);
        if (sel < 6) begin
          // fresh matrix: small values, scaled identity or full range
          style = $urandom_range(2);
          diag = W'($urandom_range(1, 3)) * ONE;
          for (int e = 0; e < 16; e++) begin
            it = noise_item(ACT_LOAD);
            it.index = 4'(e);
            if (style == 0) it.value = near_unit(2 * ONE);
            else if (style == 1) it.value = (e % 5 == 0) ? diag : '0;
            send_item(it);
          end
          send_item(noise_item(ACT_DERIVE));
        end else if (sel < 10) begin
          // single element update, derive half the time
          it = noise_item(ACT_LOAD);
          if ($urandom_range(1)) it.value = near_unit(2 * ONE);
          send_item(it);
          if ($urandom_range(1)) send_item(noise_item(ACT_DERIVE));
        end else if (sel < 13) begin
          send_item(noise_item(ACT_DERIVE));
        end else begin
          it = noise_item((sel < 55) ? ACT_POINT : ACT_SPHERE);
          it.px = coord();
          it.py = coord();
          it.pz = coord();
          sel = $urandom_range(99);
          if (sel < 10) it.radius = '0;
          else if (sel < 65) it.radius = (W-1)'($urandom_range(ONE + ONE / 2));
          else if (sel < 75) it.radius = (W-1)'($urandom_range(4) * (ONE / 2));
          send_item(it);
        end
      end
      // sender pauses until every verdict is back; the edge that took the
      // last item has to be noted first
      push <= 1'b0;
      @(posedge clk_i);
      while (sb.pending() != 0) @(posedge clk_i);
    end

    // let any trailing back-end work settle
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
